/* rtl/core/fms_pkg.sv */
// Package for the top-fraction magnitude selection core.
// Holds sizes, the opcode, phase and sequencer state types.
// No dependencies.
package fms_pkg;
  localparam int MaxFeatures = 4096;
  localparam int MagWidth    = 32;
  localparam int AddrW       = $clog2(MaxFeatures);
  localparam int CntW        = AddrW + 1;
  localparam int BitW        = $clog2(MagWidth);

  typedef enum logic {OP_LOAD = 1'b0, OP_READ = 1'b1} op_t;
  typedef enum logic {PH_LOADING = 1'b0, PH_OUTPUT = 1'b1} phase_t;
  typedef enum logic [3:0] {
    S_IDLE, S_KEEP, S_CNT_RD, S_CNT, S_CNT_END, S_GT_RD, S_GT, S_GT_END,
    S_SCAN_RD, S_SCAN, S_OUT
  } state_t;
  localparam int RegKeepFraction = 0;
  localparam int RegMinKeep      = 1;
endpackage

/* rtl/core/fms_if.sv */
// Valid/ready channel interfaces for the selection core.
// Depends on fms_pkg, which fms_in_if and fms_out_if import.
interface fms_in_if import fms_pkg::*; ();
  logic valid;
  logic ready;
  logic op;
  logic signed [31:0] magnitude;
  logic last_sample;
  modport source (output valid, op, magnitude, last_sample, input ready);
  modport sink (input valid, op, magnitude, last_sample, output ready);
endinterface

interface fms_out_if import fms_pkg::*; ();
  logic valid;
  logic ready;
  logic [11:0] kept_index;
  logic signed [31:0] kept_magnitude;
  logic last_kept;
  logic none_left;
  logic overflowed;
  modport source (output valid, kept_index, kept_magnitude, last_kept, none_left,
                  overflowed, input ready);
  modport sink (input valid, kept_index, kept_magnitude, last_kept, none_left,
                overflowed, output ready);
endinterface

interface fms_cfg_if ();
  logic valid;
  logic ready;
  logic [0:0] index;
  logic [16:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/fms_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
module fms_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* rtl/core/top_fraction_magnitude_select_core.sv */
// Top-fraction magnitude selection core: loads a frame, finds the kept set
// by radix selection, returns kept features in ascending index on reads.
// Depends on fms_pkg, fms_if and fms_ram.
//
// A load that does not end the frame leaves the block idle. The closing load
// starts the selection: the keep count is computed, then one pass over the N
// stored values for each of the 32 key bits and one more pass to count values
// above the threshold, each pass going through the single store port. A read
// scans the store from where the last read stopped, one entry a cycle, then
// holds the result in an output register until it is taken. The block accepts
// one item at a time and deasserts ready while it works.
module top_fraction_magnitude_select_core import fms_pkg::*; (
  input  logic clk,
  input  logic rst,
  fms_in_if.sink   in_ch,
  fms_out_if.source out_ch,
  fms_cfg_if.sink  cfg
);
  state_t state, state_next;
  phase_t phase;
  logic [16:0] keep_fraction;
  logic [12:0] min_keep;
  logic [CntW-1:0] sample_count, keep_count, ties, scan_ptr, emitted;
  logic [CntW-1:0] rank, cnt, idx;
  logic [MagWidth-1:0] prefix;
  logic [BitW-1:0] bitn;
  logic overflow_flag;
  logic [29:0] prod;

  logic ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [MagWidth-1:0] ram_wdata, ram_rdata;
  logic [MagWidth-1:0] key_in;

  fms_ram #(.Width(MagWidth), .Depth(MaxFeatures)) u_store (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_fraction <= 17'd13107;
      min_keep <= 13'd100;
    end else if (cfg.valid) begin
      if (cfg.index == 1'(RegKeepFraction)) keep_fraction <= cfg.data;
      else min_keep <= cfg.data[12:0];
    end
  end

  logic in_fire, out_fire;
  assign in_ch.ready = (state == S_IDLE) && !out_ch.valid;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign key_in = in_ch.magnitude ^ {1'b1, {(MagWidth-1){1'b0}}};

  // Masks for the current radix bit.
  logic [MagWidth-1:0] one_m, high_m;
  assign one_m = {{(MagWidth-1){1'b0}}, 1'b1} << bitn;
  assign high_m = ~((one_m << 1) - 1'b1);
  logic fresh;
  assign fresh = (phase != PH_LOADING);
  logic [CntW-1:0] eff_count;
  assign eff_count = fresh ? '0 : sample_count;

  // Keep count of the frame that just closed.
  logic [CntW-1:0] keep_f, keep_calc;
  always_comb begin
    keep_f = (prod[29:16] > 14'(sample_count)) ? sample_count : CntW'(prod[29:16]);
    if (sample_count <= CntW'(min_keep)) keep_calc = sample_count;
    else keep_calc = (keep_f > CntW'(min_keep)) ? keep_f : CntW'(min_keep);
  end

  // A store read returns the entry addressed in the cycle before; idx tracks it.
  logic take;
  always_comb begin
    take = 1'b0;
    if (ram_rdata > prefix) take = 1'b1;
    else if (ram_rdata == prefix && ties != '0) take = 1'b1;
  end

  always_comb begin
    state_next = state;
    ram_we = 1'b0;
    ram_addr = idx[AddrW-1:0];
    ram_wdata = key_in;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (in_ch.op == OP_LOAD) begin
            ram_we = (eff_count < CntW'(MaxFeatures));
            ram_addr = eff_count[AddrW-1:0];
            if (in_ch.last_sample) state_next = S_KEEP;
          end else begin
            state_next = S_SCAN_RD;
          end
        end
      end
      S_KEEP: state_next = (keep_calc == '0) ? S_IDLE : S_CNT_RD;
      S_CNT_RD: state_next = (idx == sample_count) ? S_CNT_END : S_CNT;
      S_CNT: state_next = (idx == sample_count) ? S_CNT_END : S_CNT;
      S_CNT_END: state_next = (bitn == '0) ? S_GT_RD : S_CNT_RD;
      S_GT_RD: state_next = S_GT;
      S_GT: state_next = (idx == sample_count) ? S_GT_END : S_GT;
      S_GT_END: state_next = S_IDLE;
      S_SCAN_RD: begin
        ram_addr = scan_ptr[AddrW-1:0];
        if (phase != PH_OUTPUT || emitted >= keep_count || scan_ptr >= sample_count)
          state_next = S_OUT;
        else
          state_next = S_SCAN;
      end
      S_SCAN: begin
        ram_addr = scan_ptr[AddrW-1:0];
        if (take) state_next = S_OUT;
        else if (scan_ptr < sample_count) state_next = S_SCAN;
        else state_next = S_OUT;
      end
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_LOADING;
      sample_count <= '0;
      keep_count <= '0;
      ties <= '0;
      scan_ptr <= '0;
      emitted <= '0;
      overflow_flag <= 1'b0;
      prefix <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_fire) out_ch.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_fire && in_ch.op == OP_LOAD) begin
            phase <= PH_LOADING;
            if (eff_count < CntW'(MaxFeatures)) begin
              sample_count <= eff_count + 1'b1;
              overflow_flag <= fresh ? 1'b0 : overflow_flag;
            end else begin
              sample_count <= eff_count;
              overflow_flag <= 1'b1;
            end
            prod <= 30'(keep_fraction) * 30'(eff_count +
                    CntW'(eff_count < CntW'(MaxFeatures)));
          end else if (in_fire) begin
            out_ch.kept_index <= '0;
            out_ch.kept_magnitude <= '0;
            out_ch.last_kept <= 1'b0;
            out_ch.none_left <= 1'b1;
            out_ch.overflowed <= overflow_flag;
            idx <= scan_ptr;
          end
        end
        S_KEEP: begin
          keep_count <= keep_calc;
          rank <= keep_calc;
          phase <= PH_OUTPUT;
          prefix <= '0;
          ties <= '0;
          scan_ptr <= '0;
          emitted <= '0;
          bitn <= BitW'(MagWidth - 1);
          idx <= '0;
          cnt <= '0;
        end
        S_CNT_RD: begin
          idx <= idx + 1'b1;
        end
        S_CNT: begin
          if ((ram_rdata & high_m) == (prefix & high_m) && (ram_rdata & one_m) != '0)
            cnt <= cnt + 1'b1;
          if (idx != sample_count) idx <= idx + 1'b1;
        end
        S_CNT_END: begin
          if (cnt >= rank) prefix <= prefix | one_m;
          else rank <= rank - cnt;
          cnt <= '0;
          idx <= '0;
          bitn <= bitn - 1'b1;
        end
        S_GT_RD: idx <= idx + 1'b1;
        S_GT: begin
          if (ram_rdata > prefix) cnt <= cnt + 1'b1;
          if (idx != sample_count) idx <= idx + 1'b1;
        end
        S_GT_END: ties <= keep_count - cnt;
        S_SCAN_RD: begin
          if (phase == PH_OUTPUT && emitted < keep_count && scan_ptr < sample_count)
            scan_ptr <= scan_ptr + 1'b1;
        end
        S_SCAN: begin
          if (take) begin
            if (!(ram_rdata > prefix)) ties <= ties - 1'b1;
            emitted <= emitted + 1'b1;
            out_ch.kept_index <= idx[11:0];
            out_ch.kept_magnitude <= ram_rdata ^ {1'b1, {(MagWidth-1){1'b0}}};
            out_ch.last_kept <= (emitted + 1'b1 == keep_count);
            out_ch.none_left <= 1'b0;
          end else if (scan_ptr < sample_count) begin
            idx <= scan_ptr;
            scan_ptr <= scan_ptr + 1'b1;
          end
        end
        S_OUT: out_ch.valid <= 1'b1;
        default: ;
      endcase
    end
  end
endmodule

/* test/tb_top_fraction_magnitude_select_core.sv */
// Testbench for the top-fraction magnitude selection core: drives frames of
// loads and reads, predicts every read beat and checks it field by field.
// Depends on fms_pkg, the fms_if channel interfaces and the core itself.
module tb_top_fraction_magnitude_select_core;
  import fms_pkg::*;

  typedef struct {
    op_t         op;
    logic [31:0] mag;
    logic        last;
  } feat_item_t;

  typedef struct {
    logic [11:0] idx;
    logic [31:0] mag;
    logic        last;
    logic        none;
    logic        ovf;
  } kept_beat_t;

  logic clk;
  logic rst;

  fms_in_if  in_ch();
  fms_out_if out_ch();
  fms_cfg_if cfg();

  top_fraction_magnitude_select_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  feat_item_t pending_items[$];
  kept_beat_t kept_expected[$];
  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int loads_sent;
  int reads_sent;
  int beats_checked;
  int none_beats;

  // Predictor state; keys hold the magnitude with its sign bit flipped.
  logic [31:0] key_store [MaxFeatures];
  int          frame_count;
  int          keep_n;
  logic [31:0] thresh_key;
  int          ties_left;
  int          scan_at;
  int          emitted;
  phase_t      frame_ph;
  logic        ovf_flag;
  logic [16:0] fraction_reg;
  logic [12:0] min_keep_reg;
  int          selected_n;

  function automatic void select_strongest();
    longint unsigned f;
    int rank;
    int cnt;
    int greater;
    logic [31:0] prefix;
    logic [31:0] high_mask;
    f = 0;
    rank = 0;
    greater = 0;
    prefix = '0;
    selected_n = frame_count;
    if (frame_count <= min_keep_reg) begin
      keep_n = frame_count;
    end else begin
      f = (longint'(fraction_reg) * longint'(frame_count)) >> 16;
      keep_n = (f > min_keep_reg) ? int'(f) : int'(min_keep_reg);
      if (keep_n > frame_count) keep_n = frame_count;
    end
    thresh_key = '0;
    ties_left = 0;
    scan_at = 0;
    emitted = 0;
    frame_ph = PH_OUTPUT;
    if (keep_n == 0) return;
    rank = keep_n;
    for (int b = MagWidth - 1; b >= 0; b--) begin
      high_mask = ~((32'd2 << b) - 32'd1);
      if (b == 31) high_mask = '0;
      cnt = 0;
      for (int i = 0; i < frame_count; i++)
        if ((key_store[i] & high_mask) == (prefix & high_mask) && key_store[i][b]) cnt++;
      if (cnt >= rank) prefix[b] = 1'b1;
      else rank -= cnt;
    end
    thresh_key = prefix;
    for (int i = 0; i < frame_count; i++)
      if (key_store[i] > prefix) greater++;
    ties_left = keep_n - greater;
  endfunction

  function automatic void predict_item(feat_item_t it);
    kept_beat_t r;
    logic [31:0] k;
    logic take;
    if (it.op == OP_LOAD) begin
      loads_sent++;
      if (frame_ph != PH_LOADING) begin
        frame_ph = PH_LOADING;
        frame_count = 0;
        ovf_flag = 1'b0;
      end
      if (frame_count < MaxFeatures) begin
        key_store[frame_count] = it.mag ^ 32'h8000_0000;
        frame_count++;
      end else begin
        ovf_flag = 1'b1;
      end
      if (it.last) select_strongest();
      return;
    end
    reads_sent++;
    r = '{idx: '0, mag: '0, last: 1'b0, none: 1'b1, ovf: ovf_flag};
    if (frame_ph == PH_OUTPUT && emitted < keep_n) begin
      while (scan_at < frame_count) begin
        k = key_store[scan_at];
        take = 1'b0;
        if (k > thresh_key) begin
          take = 1'b1;
        end else if (k == thresh_key && ties_left > 0) begin
          ties_left--;
          take = 1'b1;
        end
        scan_at++;
        if (take) begin
          emitted++;
          r.idx = 12'(scan_at - 1);
          r.mag = k ^ 32'h8000_0000;
          r.last = (emitted == keep_n);
          r.none = 1'b0;
          break;
        end
      end
    end
    kept_expected.insert(kept_expected.size(), r);
  endfunction

  // Input driver: one beat per handshake, with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.op <= OP_LOAD;
      in_ch.magnitude <= '0;
      in_ch.last_sample <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        predict_item('{op: op_t'(in_ch.op), mag: in_ch.magnitude, last: in_ch.last_sample});
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.op <= pending_items[0].op;
          in_ch.magnitude <= pending_items[0].mag;
          in_ch.last_sample <= pending_items[0].last;
          void'(pending_items.pop_front());
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and random back-pressure.
  always @(posedge clk) begin
    kept_beat_t e;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_ch.valid && out_ch.ready) begin
        beats_checked++;
        if (kept_expected.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected beat idx=%0d mag=%h", $realtime, out_ch.kept_index,
                   out_ch.kept_magnitude);
        end else begin
          e = kept_expected.pop_front();
          if (e.none) none_beats++;
          if (out_ch.kept_index !== e.idx || out_ch.kept_magnitude !== e.mag ||
              out_ch.last_kept !== e.last || out_ch.none_left !== e.none ||
              out_ch.overflowed !== e.ovf) begin
            mismatches++;
            $display("%0t: expected idx=%0d mag=%h last=%b none=%b ovf=%b, got idx=%0d mag=%h last=%b none=%b ovf=%b",
                     $realtime, e.idx, e.mag, e.last, e.none, e.ovf, out_ch.kept_index,
                     out_ch.kept_magnitude, out_ch.last_kept, out_ch.none_left,
                     out_ch.overflowed);
          end
        end
      end
    end
  end

  function automatic void push(op_t op, logic [31:0] mag, logic last);
    pending_items.insert(pending_items.size(), '{op: op, mag: mag, last: last});
  endfunction

  function automatic logic [31:0] pick_mag(int style);
    logic [31:0] tie_vals [5] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
    case (style)
      0: return $urandom;
      1: return tie_vals[$urandom_range(4)];
      default: return 32'($signed($urandom_range(200)) - 100) <<< 16;
    endcase
  endfunction

  // One frame of n loads followed by a number of reads; noise is sprinkled in.
  function automatic void add_frame(int n, int reads);
    int style;
    style = $urandom_range(2);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 4) push(OP_READ, $urandom, $urandom_range(1));
      push(OP_LOAD, pick_mag(style), i == n - 1);
    end
    for (int i = 0; i < reads; i++) push(OP_READ, $urandom, $urandom_range(1));
  endfunction

  task automatic drain();
    while (pending_items.size() > 0 || in_ch.valid || kept_expected.size() > 0)
      @(posedge clk);
    repeat (33 * (selected_n + 2) + 20) @(posedge clk);
  endtask

  task automatic write_reg(int idx, logic [16:0] value);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= 1'(idx);
    cfg.data <= value;
    forever begin
      @(posedge clk);
      if (cfg.ready) break;
    end
    cfg.valid <= 1'b0;
    if (idx == RegKeepFraction) fraction_reg = value;
    else min_keep_reg = value[12:0];
  endtask

  initial begin
    logic [16:0] fr_set [6] = '{17'd65536, 17'd1, 17'd40000, 17'd131071, 17'd13107, 17'd32768};
    logic [12:0] mk_set [6] = '{13'd0, 13'd0, 13'd3, 13'd1, 13'd4096, 13'd7};
    int target;
    int n;
    rst = 1'b1;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_LOAD;
    in_ch.magnitude = '0;
    in_ch.last_sample = 1'b0;
    out_ch.ready = 1'b0;
    mismatches = 0;
    loads_sent = 0;
    reads_sent = 0;
    beats_checked = 0;
    none_beats = 0;
    frame_count = 0;
    keep_n = 0;
    thresh_key = '0;
    ties_left = 0;
    scan_at = 0;
    emitted = 0;
    frame_ph = PH_LOADING;
    ovf_flag = 1'b0;
    fraction_reg = 17'd13107;
    min_keep_reg = 13'd100;
    selected_n = 0;
    send_idle_pct = 28;
    recv_idle_pct = 63;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: read while loading, extremes, ties, reads past the end.
    push(OP_READ, 32'hFFFF_FFFF, 1'b1);
    push(OP_LOAD, 32'h7FFF_FFFF, 1'b0);
    push(OP_LOAD, 32'h8000_0000, 1'b0);
    push(OP_LOAD, 32'h0, 1'b0);
    push(OP_LOAD, 32'hFFFF_FFFF, 1'b1);
    for (int i = 0; i < 5; i++) push(OP_READ, 32'h0, 1'b0);
    for (int i = 0; i < 3; i++) push(OP_LOAD, 32'h0001_0000, i == 2);
    push(OP_READ, 32'h0, 1'b0);
    // A new frame while results are still unread drops them.
    push(OP_LOAD, 32'h1234_5678, 1'b1);
    push(OP_READ, 32'h0, 1'b0);
    push(OP_READ, 32'h0, 1'b0);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 63 : 0;
      recv_idle_pct = (ph == 0) ? 63 : (ph == 1) ? 28 : 0;
      for (int s = 0; s < 6; s++) begin
        write_reg(RegKeepFraction, fr_set[s]);
        write_reg(RegMinKeep, 17'(mk_set[s]));
        target = loads_sent + reads_sent + 48;
        while (loads_sent + reads_sent + pending_items.size() < target) begin
          n = ($urandom_range(19) == 0) ? 60 : $urandom_range(1, 20);
          add_frame(n, ($urandom_range(9) == 0) ? $urandom_range(0, 2)
                                                 : $urandom_range(0, n + 2));
        end
        drain();
      end
    end

    $display("Covered %0d loads and %0d reads; %0d read beats checked, %0d with nothing left.",
             loads_sent, reads_sent, beats_checked, none_beats);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("Mismatches found");
    $finish;
  end
endmodule
